[design/fvca_pkg.sv]
// Shared types, constants and fixed-point helpers for the finite-volume coefficient block.
// No dependencies; used by fvca_div and finite_volume_coeff_assembly.
package fvca_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int QUO_W     = DATA_W;

    localparam logic signed [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN_V = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] RND_Q = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

    typedef enum logic [0:0] {
        REG_DIFFUSIVITY = 1'b0,
        REG_TIME_STEP   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                     is_interior;
        logic signed [DATA_W-1:0] left_x;
        logic signed [DATA_W-1:0] top_y;
        logic signed [DATA_W-1:0] right_x;
        logic signed [DATA_W-1:0] bottom_y;
        logic [30:0]              k_left;
        logic [30:0]              k_right;
        logic [30:0]              k_up;
        logic [30:0]              k_down;
        logic signed [DATA_W-1:0] boundary_value;
        logic signed [DATA_W-1:0] source_density;
        logic signed [DATA_W-1:0] previous_value;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] center_x;
        logic signed [DATA_W-1:0] center_y;
        logic signed [DATA_W-1:0] coeff_left;
        logic signed [DATA_W-1:0] coeff_right;
        logic signed [DATA_W-1:0] coeff_up;
        logic signed [DATA_W-1:0] coeff_down;
        logic signed [DATA_W-1:0] coeff_center;
        logic signed [DATA_W-1:0] coeff_constant;
        logic                     math_error;
    } out_t;

    typedef struct packed {
        logic                     err;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    // Clamp a value one bit wider than the data range.
    function automatic sat_t sat_wide(input logic signed [DATA_W:0] x);
        sat_t r;
        r.err = x[DATA_W] != x[DATA_W-1];
        r.val = r.err ? (x[DATA_W] ? MIN_V : MAX_V) : x[DATA_W-1:0];
        return r;
    endfunction

    function automatic sat_t sat_add(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
        return sat_wide({a[DATA_W-1], a} + {b[DATA_W-1], b});
    endfunction

    function automatic sat_t sat_sub(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
        return sat_wide({a[DATA_W-1], a} - {b[DATA_W-1], b});
    endfunction

    // Scale a full product back to Qm.n, truncating toward zero, and clamp.
    function automatic sat_t mulq_fin(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        sat_t                     r;
        t     = p + (p[PROD_W-1] ? RND_Q : PROD_W'(0));
        t     = t >>> FRAC_BITS;
        r.err = t[PROD_W-1:DATA_W-1] != {(PROD_W-DATA_W+1){t[DATA_W-1]}};
        r.val = r.err ? (t[PROD_W-1] ? MIN_V : MAX_V) : t[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] x);
        return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
    endfunction

endpackage

[design/finite_volume_coeff_assembly.sv]
// Top level: finite-volume heat-conduction coefficient assembly, Q16.16.
// Depends on fvca_pkg and fvca_div.

// One control volume enters per beat on start; busy is always low, so a new cell can
// follow in every cycle. Each cell comes back on result, marked by a one-cycle done
// strobe, in input order. It passes eight stages of geometry, products and overflow
// checks, then the five 32-stage dividers (four faces and the capacity term), which
// produce one quotient bit per stage, then four stages of sums. There is no
// back-pressure: the receiver must take every done beat. Write diffusivity_factor and
// time_step only while no cell is in flight; cfg_ready is always high.
module finite_volume_coeff_assembly (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  fvca_pkg::in_t   item,
    output logic            done,
    output fvca_pkg::out_t  result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [0:0]      cfg_index,
    input  logic [31:0]     cfg_data
);

    localparam int W     = fvca_pkg::DATA_W;
    localparam int PW    = fvca_pkg::PROD_W;
    localparam int QW    = fvca_pkg::QUO_W;
    localparam int LANES = 5;
    localparam int L_LEFT = 0;
    localparam int L_RIGHT = 1;
    localparam int L_UP = 2;
    localparam int L_DOWN = 3;
    localparam int L_CAP = 4;

    typedef struct packed {
        logic                interior;
        logic                err;
        logic [LANES-1:0]    ovf;
        logic [LANES-1:0]    neg;
        logic [3:0]          zero;
        logic                dtz;
        logic signed [W-1:0] cx;
        logic signed [W-1:0] cy;
        logic signed [W-1:0] srca;
        logic signed [W-1:0] prev;
        logic signed [W-1:0] bval;
    } side_t;

    // ---------------------------------------------------------------- config
    logic [30:0] alpha_reg;
    logic [30:0] dt_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 31'(fvca_pkg::ONE_Q);
            dt_reg    <= 31'(fvca_pkg::ONE_Q);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (fvca_pkg::cfg_reg_t'(cfg_index))
                fvca_pkg::REG_DIFFUSIVITY: alpha_reg <= cfg_data[30:0];
                fvca_pkg::REG_TIME_STEP:   dt_reg    <= cfg_data[30:0];
                default:                   alpha_reg <= alpha_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------- valid chain
    logic          s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic          s5_vld_reg, s6_vld_reg, s7_vld_reg, s8_vld_reg;
    logic [QW-1:0] div_vld_reg;
    logic          p1_vld_reg, p2_vld_reg, p3_vld_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            div_vld_reg <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= start && !busy;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            div_vld_reg <= {div_vld_reg[QW-2:0], s8_vld_reg};
            p1_vld_reg  <= div_vld_reg[QW-1];
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            done_reg    <= p3_vld_reg;
        end
    end

    assign done = done_reg;

    // ---------------------------------------------------------------- S1: capture beat
    fvca_pkg::in_t s1_item_reg;

    always_ff @(posedge clk)
    begin
        s1_item_reg <= item;
    end

    // ---------------------------------------------------------------- S2: centre
    fvca_pkg::in_t       s2_item_reg;
    logic signed [W-1:0] s2_cx_reg, s2_cy_reg;
    logic signed [W:0]   sum_x, sum_y;
    logic signed [W-1:0] s2_cx_next, s2_cy_next;

    always_comb
    begin
        // floor of the half-sum is the upper bits of the wide sum
        sum_x      = {s1_item_reg.left_x[W-1], s1_item_reg.left_x}
                   + {s1_item_reg.right_x[W-1], s1_item_reg.right_x};
        sum_y      = {s1_item_reg.top_y[W-1], s1_item_reg.top_y}
                   + {s1_item_reg.bottom_y[W-1], s1_item_reg.bottom_y};
        s2_cx_next = sum_x[W:1];
        s2_cy_next = sum_y[W:1];
    end

    always_ff @(posedge clk)
    begin
        s2_item_reg <= s1_item_reg;
        s2_cx_reg   <= s2_cx_next;
        s2_cy_reg   <= s2_cy_next;
    end

    // ---------------------------------------------------------------- S3: half-widths
    fvca_pkg::in_t       s3_item_reg;
    logic signed [W-1:0] s3_cx_reg, s3_cy_reg;
    logic signed [W-1:0] s3_hl_reg, s3_hr_reg, s3_hd_reg, s3_hu_reg;
    logic                s3_err_reg;
    fvca_pkg::sat_t      hl_s, hr_s, hd_s, hu_s;

    always_comb
    begin
        hl_s = fvca_pkg::sat_sub(s2_cx_reg, s2_item_reg.left_x);
        hr_s = fvca_pkg::sat_sub(s2_item_reg.right_x, s2_cx_reg);
        hd_s = fvca_pkg::sat_sub(s2_cy_reg, s2_item_reg.bottom_y);
        hu_s = fvca_pkg::sat_sub(s2_item_reg.top_y, s2_cy_reg);
    end

    always_ff @(posedge clk)
    begin
        s3_item_reg <= s2_item_reg;
        s3_cx_reg   <= s2_cx_reg;
        s3_cy_reg   <= s2_cy_reg;
        s3_hl_reg   <= hl_s.val;
        s3_hr_reg   <= hr_s.val;
        s3_hd_reg   <= hd_s.val;
        s3_hu_reg   <= hu_s.val;
        s3_err_reg  <= hl_s.err | hr_s.err | hd_s.err | hu_s.err;
    end

    // ---------------------------------------------------------------- S4: width, height
    fvca_pkg::in_t       s4_item_reg;
    logic signed [W-1:0] s4_cx_reg, s4_cy_reg;
    logic signed [W-1:0] s4_hl_reg, s4_hr_reg, s4_hd_reg, s4_hu_reg;
    logic signed [W-1:0] s4_wx_reg, s4_wy_reg;
    logic                s4_err_reg;
    fvca_pkg::sat_t      wx_s, wy_s;

    always_comb
    begin
        wx_s = fvca_pkg::sat_add(s3_hl_reg, s3_hr_reg);
        wy_s = fvca_pkg::sat_add(s3_hd_reg, s3_hu_reg);
    end

    always_ff @(posedge clk)
    begin
        s4_item_reg <= s3_item_reg;
        s4_cx_reg   <= s3_cx_reg;
        s4_cy_reg   <= s3_cy_reg;
        s4_hl_reg   <= s3_hl_reg;
        s4_hr_reg   <= s3_hr_reg;
        s4_hd_reg   <= s3_hd_reg;
        s4_hu_reg   <= s3_hu_reg;
        s4_wx_reg   <= wx_s.val;
        s4_wy_reg   <= wy_s.val;
        s4_err_reg  <= s3_err_reg | wx_s.err | wy_s.err;
    end

    // ---------------------------------------------------------------- S5: products
    // Faces work on magnitudes; the sign travels beside them.
    fvca_pkg::in_t        s5_item_reg;
    logic signed [W-1:0]  s5_cx_reg, s5_cy_reg;
    logic signed [PW-1:0] s5_area_p_reg;
    logic [PW-1:0]        s5_fp_reg [4];
    logic [W-1:0]         s5_fc_reg [4];
    logic [3:0]           s5_neg_reg, s5_zero_reg;
    logic                 s5_err_reg;
    logic signed [PW-1:0] s5_area_p_next;
    logic [PW-1:0]        s5_fp_next [4];
    logic [W-1:0]         s5_fc_next [4];
    logic [3:0]           s5_neg_next, s5_zero_next;
    logic [W-1:0]         wx_mag, wy_mag;
    logic [W-1:0]         h_mag [4];
    logic signed [W-1:0]  h_val [4];

    always_comb
    begin
        wx_mag         = fvca_pkg::mag(s4_wx_reg);
        wy_mag         = fvca_pkg::mag(s4_wy_reg);
        h_val[L_LEFT]  = s4_hl_reg;
        h_val[L_RIGHT] = s4_hr_reg;
        h_val[L_UP]    = s4_hu_reg;
        h_val[L_DOWN]  = s4_hd_reg;
        s5_area_p_next = s4_wx_reg * s4_wy_reg;
        s5_fp_next[L_LEFT]  = PW'(s4_item_reg.k_left)  * PW'(wy_mag);
        s5_fp_next[L_RIGHT] = PW'(s4_item_reg.k_right) * PW'(wy_mag);
        s5_fp_next[L_UP]    = PW'(s4_item_reg.k_up)    * PW'(wx_mag);
        s5_fp_next[L_DOWN]  = PW'(s4_item_reg.k_down)  * PW'(wx_mag);
        s5_neg_next[L_LEFT]  = s4_wy_reg[W-1] ^ s4_hl_reg[W-1];
        s5_neg_next[L_RIGHT] = s4_wy_reg[W-1] ^ s4_hr_reg[W-1];
        s5_neg_next[L_UP]    = s4_wx_reg[W-1] ^ s4_hu_reg[W-1];
        s5_neg_next[L_DOWN]  = s4_wx_reg[W-1] ^ s4_hd_reg[W-1];
        for (int j = 0; j < 4; j++)
        begin
            h_mag[j]        = fvca_pkg::mag(h_val[j]);
            s5_zero_next[j] = h_val[j] == '0;
            // keep the divider well defined on a zero half-width; result is dropped
            s5_fc_next[j]   = s5_zero_next[j] ? W'(1) : h_mag[j];
        end
    end

    always_ff @(posedge clk)
    begin
        s5_item_reg   <= s4_item_reg;
        s5_cx_reg     <= s4_cx_reg;
        s5_cy_reg     <= s4_cy_reg;
        s5_area_p_reg <= s5_area_p_next;
        s5_fp_reg     <= s5_fp_next;
        s5_fc_reg     <= s5_fc_next;
        s5_neg_reg    <= s5_neg_next;
        s5_zero_reg   <= s5_zero_next;
        s5_err_reg    <= s4_err_reg;
    end

    // ---------------------------------------------------------------- S6: area
    fvca_pkg::in_t       s6_item_reg;
    logic signed [W-1:0] s6_cx_reg, s6_cy_reg, s6_area_reg;
    logic [PW-1:0]       s6_fp_reg [4];
    logic [W-1:0]        s6_fc_reg [4];
    logic [3:0]          s6_neg_reg, s6_zero_reg;
    logic                s6_err_reg;
    fvca_pkg::sat_t      area_s;

    assign area_s = fvca_pkg::mulq_fin(s5_area_p_reg);

    always_ff @(posedge clk)
    begin
        s6_item_reg <= s5_item_reg;
        s6_cx_reg   <= s5_cx_reg;
        s6_cy_reg   <= s5_cy_reg;
        s6_area_reg <= area_s.val;
        s6_fp_reg   <= s5_fp_reg;
        s6_fc_reg   <= s5_fc_reg;
        s6_neg_reg  <= s5_neg_reg;
        s6_zero_reg <= s5_zero_reg;
        s6_err_reg  <= s5_err_reg | area_s.err;
    end

    // ---------------------------------------------------------------- S7: capacity and source products
    fvca_pkg::in_t        s7_item_reg;
    logic signed [W-1:0]  s7_cx_reg, s7_cy_reg;
    logic [PW-1:0]        s7_p_reg [LANES];
    logic [W-1:0]         s7_c_reg [LANES];
    logic [LANES-1:0]     s7_neg_reg;
    logic [3:0]           s7_zero_reg;
    logic                 s7_dtz_reg, s7_err_reg;
    logic signed [PW-1:0] s7_srca_p_reg;
    logic [PW-1:0]        cap_p_next;
    logic signed [PW-1:0] s7_srca_p_next;

    always_comb
    begin
        cap_p_next     = PW'(alpha_reg) * PW'(fvca_pkg::mag(s6_area_reg));
        s7_srca_p_next = s6_item_reg.source_density * s6_area_reg;
    end

    always_ff @(posedge clk)
    begin
        s7_item_reg   <= s6_item_reg;
        s7_cx_reg     <= s6_cx_reg;
        s7_cy_reg     <= s6_cy_reg;
        for (int j = 0; j < 4; j++)
        begin
            s7_p_reg[j] <= s6_fp_reg[j];
            s7_c_reg[j] <= s6_fc_reg[j];
        end
        s7_p_reg[L_CAP] <= cap_p_next;
        s7_c_reg[L_CAP] <= (dt_reg == '0) ? W'(1) : W'(dt_reg);
        s7_neg_reg    <= {s6_area_reg[W-1], s6_neg_reg};
        s7_zero_reg   <= s6_zero_reg;
        s7_dtz_reg    <= dt_reg == '0;
        s7_srca_p_reg <= s7_srca_p_next;
        s7_err_reg    <= s6_err_reg;
    end

    // ---------------------------------------------------------------- S8: overflow check
    // q > limit exactly when P >= (limit + 1) * C; limit + 1 is 2**31 for a positive
    // quotient and 2**31 + 1 for a negative one.
    side_t            s8_side_reg;
    logic [PW-1:0]    s8_p_reg [LANES];
    logic [W-1:0]     s8_c_reg [LANES];
    side_t            s8_side_next;
    logic [PW-1:0]    ovf_lim [LANES];
    fvca_pkg::sat_t   srca_s;

    always_comb
    begin
        srca_s = fvca_pkg::mulq_fin(s7_srca_p_reg);
        s8_side_next.interior = s7_item_reg.is_interior;
        s8_side_next.err      = s7_err_reg | srca_s.err;
        s8_side_next.neg      = s7_neg_reg;
        s8_side_next.zero     = s7_zero_reg;
        s8_side_next.dtz      = s7_dtz_reg;
        s8_side_next.cx       = s7_cx_reg;
        s8_side_next.cy       = s7_cy_reg;
        s8_side_next.srca     = srca_s.val;
        s8_side_next.prev     = s7_item_reg.previous_value;
        s8_side_next.bval     = s7_item_reg.boundary_value;
        for (int j = 0; j < LANES; j++)
        begin
            ovf_lim[j] = (PW'(s7_c_reg[j]) << (W - 1))
                       + (s7_neg_reg[j] ? PW'(s7_c_reg[j]) : PW'(0));
            s8_side_next.ovf[j] = s7_p_reg[j] >= ovf_lim[j];
        end
    end

    always_ff @(posedge clk)
    begin
        s8_side_reg <= s8_side_next;
        s8_p_reg    <= s7_p_reg;
        s8_c_reg    <= s7_c_reg;
    end

    // ---------------------------------------------------------------- dividers
    logic [QW-1:0] div_q [LANES];
    side_t         side_reg [QW];

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            fvca_div u_div (
                .clk      (clk),
                .dividend (s8_p_reg[g]),
                .divisor  (s8_c_reg[g]),
                .quotient (div_q[g])
            );
        end
    endgenerate

    // hold the sideband alongside the quotient bits
    always_ff @(posedge clk)
    begin
        side_reg[0] <= s8_side_reg;
        for (int j = 1; j < QW; j++)
        begin
            side_reg[j] <= side_reg[j-1];
        end
    end

    // ---------------------------------------------------------------- P1: signed quotients
    side_t               p1_side_reg;
    logic signed [W-1:0] p1_q_reg [LANES];
    logic                p1_err_reg;
    side_t               dsd;
    logic [LANES-1:0]    drop;
    logic signed [W-1:0] p1_q_next [LANES];
    logic                p1_err_next;

    always_comb
    begin
        dsd         = side_reg[QW-1];
        drop        = {dsd.dtz, dsd.zero};
        p1_err_next = dsd.err | (|drop);
        for (int j = 0; j < LANES; j++)
        begin
            if (drop[j])
            begin
                p1_q_next[j] = '0;
            end
            else if (dsd.ovf[j])
            begin
                p1_q_next[j] = dsd.neg[j] ? fvca_pkg::MIN_V : fvca_pkg::MAX_V;
            end
            else
            begin
                p1_q_next[j] = dsd.neg[j] ? W'(-div_q[j]) : W'(div_q[j]);
            end
            p1_err_next = p1_err_next | (dsd.ovf[j] & ~drop[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        p1_side_reg <= dsd;
        p1_q_reg    <= p1_q_next;
        p1_err_reg  <= p1_err_next;
    end

    // ---------------------------------------------------------------- P2: left + right + up
    side_t                p2_side_reg;
    logic signed [W-1:0]  p2_ctr_reg, p2_down_reg, p2_cap_reg;
    logic signed [PW-1:0] p2_cp_p_reg;
    logic                 p2_err_reg;
    fvca_pkg::sat_t       a1_s, a2_s;

    always_comb
    begin
        a1_s = fvca_pkg::sat_add(p1_q_reg[L_LEFT], p1_q_reg[L_RIGHT]);
        a2_s = fvca_pkg::sat_add(a1_s.val, p1_q_reg[L_UP]);
    end

    always_ff @(posedge clk)
    begin
        p2_side_reg <= p1_side_reg;
        p2_ctr_reg  <= a2_s.val;
        p2_down_reg <= p1_q_reg[L_DOWN];
        p2_cap_reg  <= p1_q_reg[L_CAP];
        p2_cp_p_reg <= p1_q_reg[L_CAP] * p1_side_reg.prev;
        p2_err_reg  <= p1_err_reg | a1_s.err | a2_s.err;
    end

    // ---------------------------------------------------------------- P3: + down + capacity
    side_t               p3_side_reg;
    logic signed [W-1:0] p3_ctr_reg, p3_const_reg;
    logic signed [W-1:0] p3_face_reg [4];
    logic                p3_err_reg;
    fvca_pkg::sat_t      a3_s, a4_s, cst_s;
    logic signed [W-1:0] p2_face [4];

    always_comb
    begin
        a3_s  = fvca_pkg::sat_add(p2_ctr_reg, p2_down_reg);
        a4_s  = fvca_pkg::sat_add(a3_s.val, p2_cap_reg);
        cst_s = fvca_pkg::mulq_fin(p2_cp_p_reg);
    end

    // neighbour values ride along for the output mux
    logic signed [W-1:0] p2_face_reg [4];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            p2_face_reg[j] <= p1_q_reg[j];
        end
    end

    assign p2_face = p2_face_reg;

    always_ff @(posedge clk)
    begin
        p3_side_reg  <= p2_side_reg;
        p3_ctr_reg   <= a4_s.val;
        p3_const_reg <= cst_s.val;
        p3_face_reg  <= p2_face;
        p3_err_reg   <= p2_err_reg | a3_s.err | a4_s.err | cst_s.err;
    end

    // ---------------------------------------------------------------- P4: source term, output
    fvca_pkg::out_t result_reg;
    fvca_pkg::out_t result_next;
    fvca_pkg::sat_t a5_s;

    always_comb
    begin
        a5_s                   = fvca_pkg::sat_sub(p3_ctr_reg, p3_side_reg.srca);
        result_next.center_x   = p3_side_reg.cx;
        result_next.center_y   = p3_side_reg.cy;
        if (p3_side_reg.interior)
        begin
            result_next.coeff_left     = p3_face_reg[L_LEFT];
            result_next.coeff_right    = p3_face_reg[L_RIGHT];
            result_next.coeff_up       = p3_face_reg[L_UP];
            result_next.coeff_down     = p3_face_reg[L_DOWN];
            result_next.coeff_center   = a5_s.val;
            result_next.coeff_constant = p3_const_reg;
            result_next.math_error     = p3_err_reg | a5_s.err;
        end
        else
        begin
            // boundary cell: fixed value, no neighbours, never an error
            result_next.coeff_left     = '0;
            result_next.coeff_right    = '0;
            result_next.coeff_up       = '0;
            result_next.coeff_down     = '0;
            result_next.coeff_center   = fvca_pkg::ONE_Q;
            result_next.coeff_constant = p3_side_reg.bval;
            result_next.math_error     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

`ifndef SYNTH
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg == $past(s8_vld_reg, QW + 4))
        else $error("done strobe out of step with the divider pipeline");

    a_zero_half : assert property (@(posedge clk) disable iff (!rst_n)
        (div_vld_reg[QW-1] && (|side_reg[QW-1].zero)) |=> p1_err_reg)
        else $error("zero half-width did not raise the error flag");

    a_ovf_clamp : assert property (@(posedge clk) disable iff (!rst_n)
        (div_vld_reg[QW-1] && side_reg[QW-1].ovf[L_LEFT] && !side_reg[QW-1].zero[L_LEFT])
        |=> (p1_q_reg[L_LEFT] == fvca_pkg::MAX_V || p1_q_reg[L_LEFT] == fvca_pkg::MIN_V))
        else $error("left coefficient overflow not clamped");
`endif

endmodule

[design/fvca_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on fvca_pkg; the caller guarantees dividend < divisor * 2**QUO_W.
module fvca_div (
    input  logic                        clk,
    input  logic [fvca_pkg::PROD_W-1:0] dividend,
    input  logic [fvca_pkg::QUO_W-1:0]  divisor,
    output logic [fvca_pkg::QUO_W-1:0]  quotient
);

    localparam int N = fvca_pkg::QUO_W;

    logic [N-1:0] rem_reg [N];
    logic [N-1:0] low_reg [N];
    logic [N-1:0] dvs_reg [N];
    logic [N-1:0] quo_reg [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_step
            logic [N-1:0] rem_in;
            logic [N-1:0] low_in;
            logic [N-1:0] dvs_in;
            logic [N-1:0] quo_in;
            logic [N:0]   trial;
            logic         fits;
            logic [N-1:0] rem_next;
            logic [N-1:0] quo_next;

            if (i == 0)
            begin : g_first
                assign rem_in = dividend[2*N-1:N];
                assign low_in = dividend[N-1:0];
                assign dvs_in = divisor;
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[i-1];
                assign low_in = low_reg[i-1];
                assign dvs_in = dvs_reg[i-1];
                assign quo_in = quo_reg[i-1];
            end

            // shift in the next dividend bit, subtract if it fits
            assign trial    = {rem_in, low_in[N-1]};
            assign fits     = trial >= {1'b0, dvs_in};
            assign rem_next = fits ? N'(trial - {1'b0, dvs_in}) : trial[N-1:0];
            assign quo_next = {quo_in[N-2:0], fits};

            always_ff @(posedge clk)
            begin
                rem_reg[i] <= rem_next;
                low_reg[i] <= {low_in[N-2:0], 1'b0};
                dvs_reg[i] <= dvs_in;
                quo_reg[i] <= quo_next;
            end
        end
    endgenerate

    assign quotient = quo_reg[N-1];

endmodule
